>>> design/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants for the single-wire sensor reader.
// ----------------------------------------------------------------------------
package swr_pkg;

  // tick counter width; counter saturates at its all-ones value
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int BYTE_W      = 8;
  localparam int BIT_IDX_W   = $clog2(BYTE_W);
  localparam int ACT_W       = 2;
  // compare width wide enough for both the counter and a delay register
  localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_W-1:0]       cfg_val_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [ACT_W-1:0]       action_t;

  // configuration register indexes
  localparam cfg_idx_t REG_START_LOW  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_FIRST_ACK  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_SECOND_ACK = cfg_idx_t'(2);
  localparam cfg_idx_t REG_ACK_TAIL   = cfg_idx_t'(3);
  localparam cfg_idx_t REG_BIT_SAMPLE = cfg_idx_t'(4);

  // reset values of the delay registers
  localparam cfg_val_t RST_START_LOW  = cfg_val_t'(1000);
  localparam cfg_val_t RST_FIRST_ACK  = cfg_val_t'(60);
  localparam cfg_val_t RST_SECOND_ACK = cfg_val_t'(80);
  localparam cfg_val_t RST_ACK_TAIL   = cfg_val_t'(40);
  localparam cfg_val_t RST_BIT_SAMPLE = cfg_val_t'(30);

  // action codes; the unused code behaves as a plain tick
  localparam action_t ACT_TICK  = action_t'(0);
  localparam action_t ACT_START = action_t'(1);
  localparam action_t ACT_RECV  = action_t'(2);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START_LOW,
    PH_ACK1,
    PH_ACK2,
    PH_TAIL,
    PH_WAIT_LOW,
    PH_WAIT_HIGH,
    PH_SAMPLE
  } phase_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              ack_ok;
    logic [BYTE_W-1:0] byte_value;
  } res_t;

endpackage

>>> design/single_wire_sensor_reader.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_reader
// Master side of a single-wire temperature/humidity sensor link: start pulse,
// two-point acknowledge check and MSB-first byte receive, one tick per word.
// A result word is registered from its accepted tick word into the result register, or into the skid while it is held.
// One tick word per cycle while in_stall is low; the sequencer state updates in one pass.
// A two-entry output stage (result register plus skid) decouples in_stall.
// Reset (rst_n low, synchronous): sequencer idle, flags and byte cleared,
// delay registers return to their defaults, output empty.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader
  import swr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // tick input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_W-1:0]     in_action,
  input  logic                 in_line_level,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_drive_low,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic                 out_ack_ok,
  output logic [BYTE_W-1:0]    out_byte_value
);

  localparam cnt_t CNT_MAX = {COUNT_WIDTH{1'b1}};

  // delay registers
  cfg_val_t start_low_r, first_ack_r, second_ack_r, ack_tail_r, bit_sample_r;

  // sequencer state
  phase_t                phase_r, phase_nxt;
  cnt_t                  cnt_r, cnt_nxt;
  logic [BIT_IDX_W-1:0]  bit_r, bit_nxt;
  logic [BYTE_W-1:0]     shift_r, shift_nxt;
  logic                  fas_r, fas_nxt;
  logic                  ack_r, ack_nxt;
  logic                  done_nxt;

  // output stage
  res_t res;
  res_t out_r, skid_r;
  logic out_vld_r, skid_vld_r;

  logic acc_in, out_take;

  // counter path
  cfg_val_t           sel_lim;
  logic               sel_floor;
  cnt_t               cnt_cur, cnt_inc;
  logic [CMP_W-1:0]   lim_eff, lim_ext;
  logic               reached;

  assign in_stall = skid_vld_r;
  assign acc_in   = in_valid & ~skid_vld_r;
  assign out_take = out_vld_r & ~out_stall;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_low_r  <= RST_START_LOW;
      first_ack_r  <= RST_FIRST_ACK;
      second_ack_r <= RST_SECOND_ACK;
      ack_tail_r   <= RST_ACK_TAIL;
      bit_sample_r <= RST_BIT_SAMPLE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_START_LOW:  start_low_r  <= cfg_wdata;
        REG_FIRST_ACK:  first_ack_r  <= cfg_wdata;
        REG_SECOND_ACK: second_ack_r <= cfg_wdata;
        REG_ACK_TAIL:   ack_tail_r   <= cfg_wdata;
        REG_BIT_SAMPLE: bit_sample_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- delay select and tick counter ----------------
  always_comb begin
    sel_lim   = start_low_r;
    sel_floor = 1'b1;
    unique case (phase_r)
      PH_IDLE, PH_START_LOW: sel_lim = start_low_r;
      PH_ACK1:               sel_lim = first_ack_r;
      PH_ACK2:               sel_lim = second_ack_r;
      PH_TAIL: begin
        sel_lim   = ack_tail_r;
        sel_floor = 1'b0;
      end
      PH_SAMPLE:             sel_lim = bit_sample_r;
      default:               sel_lim = start_low_r;
    endcase
  end

  always_comb begin
    lim_ext = CMP_W'(sel_lim);
    if (sel_floor && (sel_lim == '0)) begin
      lim_ext = CMP_W'(1);
    end
    // a delay beyond the counter range acts as the counter maximum
    lim_eff = (lim_ext > CMP_W'(CNT_MAX)) ? CMP_W'(CNT_MAX) : lim_ext;
    // a start command counts from zero on its own tick
    cnt_cur = (phase_r == PH_IDLE) ? '0 : cnt_r;
    cnt_inc = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + cnt_t'(1);
    reached = (CMP_W'(cnt_inc) >= lim_eff);
  end

  // ---------------- next state ----------------
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    fas_nxt   = fas_r;
    ack_nxt   = ack_r;
    done_nxt  = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_action == ACT_START) begin
          ack_nxt = 1'b0;
          if (reached) begin
            phase_nxt = PH_ACK1;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_START_LOW;
            cnt_nxt   = cnt_inc;
          end
        end else if (in_action == ACT_RECV) begin
          phase_nxt = PH_WAIT_LOW;
          cnt_nxt   = '0;
          bit_nxt   = '0;
          shift_nxt = '0;
        end
      end
      PH_START_LOW: begin
        cnt_nxt = cnt_inc;
        if (reached) begin
          phase_nxt = PH_ACK1;
          cnt_nxt   = '0;
        end
      end
      PH_ACK1: begin
        cnt_nxt = cnt_inc;
        if (reached) begin
          fas_nxt   = in_line_level;
          phase_nxt = PH_ACK2;
          cnt_nxt   = '0;
        end
      end
      PH_ACK2: begin
        cnt_nxt = cnt_inc;
        if (reached) begin
          ack_nxt = ~fas_r & in_line_level;
          cnt_nxt = '0;
          if (ack_tail_r == '0) begin
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end else begin
            phase_nxt = PH_TAIL;
          end
        end
      end
      PH_TAIL: begin
        cnt_nxt = cnt_inc;
        if (reached) begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
          done_nxt  = 1'b1;
        end
      end
      PH_WAIT_LOW: begin
        if (!in_line_level) begin
          phase_nxt = PH_WAIT_HIGH;
        end
      end
      PH_WAIT_HIGH: begin
        if (in_line_level) begin
          phase_nxt = PH_SAMPLE;
          cnt_nxt   = '0;
        end
      end
      PH_SAMPLE: begin
        cnt_nxt = cnt_inc;
        if (reached) begin
          shift_nxt = {shift_r[BYTE_W-2:0], in_line_level};
          cnt_nxt   = '0;
          if (bit_r == {BIT_IDX_W{1'b1}}) begin
            bit_nxt   = '0;
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end else begin
            bit_nxt   = bit_r + BIT_IDX_W'(1);
            phase_nxt = PH_WAIT_LOW;
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // ---------------- result word ----------------
  always_comb begin
    res.drive_low  = (phase_nxt == PH_START_LOW);
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.done_res   = done_nxt;
    res.ack_ok     = ack_nxt;
    res.byte_value = shift_nxt;
  end

  // ---------------- state registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      fas_r   <= 1'b0;
      ack_r   <= 1'b0;
    end else if (acc_in) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      fas_r   <= fas_nxt;
      ack_r   <= ack_nxt;
    end
  end

  // ---------------- output register and skid ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_take) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= acc_in;
      end
    end else if (acc_in) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_take) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (acc_in) begin
        out_r <= res;
      end
    end else if (acc_in) begin
      skid_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_drive_low  = out_r.drive_low;
  assign out_busy_res   = out_r.busy_res;
  assign out_done_res   = out_r.done_res;
  assign out_ack_ok     = out_r.ack_ok;
  assign out_byte_value = out_r.byte_value;

endmodule

>>> design/swr_checker.sv
// ----------------------------------------------------------------------------
// swr_checker
// Port-level checks for the single-wire sensor reader, bound to the top level.
// ----------------------------------------------------------------------------
module swr_checker
  import swr_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_drive_low,
  input logic                 out_busy_res,
  input logic                 out_done_res,
  input logic                 out_ack_ok,
  input logic [BYTE_W-1:0]    out_byte_value
);

  // a finished operation leaves the sequencer idle and the line released
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && !out_drive_low)
    else $error("done word shows busy or drive_low");

  // the line is only pulled low inside a running operation
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_low |-> out_busy_res)
    else $error("drive_low without busy");

  // input side only stalls when a word is already waiting at the output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall with empty output");

  // output drains empty out of reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_value)
      && $stable(out_ack_ok) && $stable(out_done_res))
    else $error("stalled result word changed");

endmodule

bind single_wire_sensor_reader swr_checker u_swr_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for single_wire_sensor_reader. A cycle-level sequencer
// model predicts one result word per accepted tick word. Start and receive
// sequences are shaped from the predicted state so they mostly run through.
// Runs use the reset delays, zero delays, long delays and random
// settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import swr_pkg::*;

  localparam action_t ACT_SPARE = action_t'(3);   // unused code, plain tick

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 cfg_we        = 1'b0;
  cfg_idx_t             cfg_idx       = '0;
  cfg_val_t             cfg_wdata     = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  action_t              in_action     = ACT_TICK;
  logic                 in_line_level = 1'b0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic                 out_drive_low;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic                 out_ack_ok;
  logic [BYTE_W-1:0]    out_byte_value;

  single_wire_sensor_reader u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_line_level (in_line_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive_low (out_drive_low),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_ack_ok    (out_ack_ok),
    .out_byte_value(out_byte_value)
  );

  always #4 clk = ~clk;

  // ---------------- sequencer model ----------------
  cfg_val_t             dl_start_low  = RST_START_LOW;
  cfg_val_t             dl_first_ack  = RST_FIRST_ACK;
  cfg_val_t             dl_second_ack = RST_SECOND_ACK;
  cfg_val_t             dl_ack_tail   = RST_ACK_TAIL;
  cfg_val_t             dl_bit_sample = RST_BIT_SAMPLE;

  phase_t               sq_phase   = PH_IDLE;
  cnt_t                 sq_count   = '0;
  logic [BIT_IDX_W-1:0] sq_bit_idx = '0;
  logic [BYTE_W-1:0]    sq_shift   = '0;
  logic                 sq_first   = 1'b0;
  logic                 sq_ack     = 1'b0;

  res_t                 expected_words[$];
  res_t                 head_word;
  logic                 bit_lvl = 1'b0;
  int                   send_gap_pct = 0;
  int                   stall_pct    = 0;
  int                   err_cnt       = 0;
  int                   ticks_sent    = 0;
  int                   words_checked = 0;
  int                   acks_ok       = 0;
  int                   acks_bad      = 0;
  int                   bytes_done    = 0;

  // bump the saturating tick counter, report whether the delay is reached
  function automatic logic count_hit(input cfg_val_t limit, input logic floor_one);
    logic [CMP_W-1:0] lim;
    logic [CMP_W-1:0] cmax;
    cmax = CMP_W'({COUNT_WIDTH{1'b1}});
    lim  = CMP_W'(limit);
    if (floor_one && lim == '0) lim = CMP_W'(1);
    if (lim > cmax) lim = cmax;
    if (sq_count != {COUNT_WIDTH{1'b1}}) sq_count = sq_count + cnt_t'(1);
    return CMP_W'(sq_count) >= lim;
  endfunction

  task automatic step_sequencer(input action_t act, input logic lvl);
    res_t w;
    logic fin;
    fin = 1'b0;
    case (sq_phase)
      PH_IDLE: begin
        if (act == ACT_START) begin
          sq_phase = PH_START_LOW;
          sq_count = '0;
          sq_ack   = 1'b0;
          // the command tick is the first low tick
          if (count_hit(dl_start_low, 1'b1)) begin
            sq_phase = PH_ACK1;
            sq_count = '0;
          end
        end else if (act == ACT_RECV) begin
          sq_phase   = PH_WAIT_LOW;
          sq_count   = '0;
          sq_bit_idx = '0;
          sq_shift   = '0;
        end
      end
      PH_START_LOW: begin
        if (count_hit(dl_start_low, 1'b1)) begin
          sq_phase = PH_ACK1;
          sq_count = '0;
        end
      end
      PH_ACK1: begin
        if (count_hit(dl_first_ack, 1'b1)) begin
          sq_first = lvl;
          sq_phase = PH_ACK2;
          sq_count = '0;
        end
      end
      PH_ACK2: begin
        if (count_hit(dl_second_ack, 1'b1)) begin
          sq_ack   = !sq_first && lvl;
          sq_count = '0;
          if (sq_ack) acks_ok++;
          else acks_bad++;
          if (dl_ack_tail == '0) begin
            sq_phase = PH_IDLE;
            fin      = 1'b1;
          end else begin
            sq_phase = PH_TAIL;
          end
        end
      end
      PH_TAIL: begin
        if (count_hit(dl_ack_tail, 1'b0)) begin
          sq_phase = PH_IDLE;
          sq_count = '0;
          fin      = 1'b1;
        end
      end
      PH_WAIT_LOW: begin
        if (!lvl) sq_phase = PH_WAIT_HIGH;
      end
      PH_WAIT_HIGH: begin
        if (lvl) begin
          sq_phase = PH_SAMPLE;
          sq_count = '0;
        end
      end
      PH_SAMPLE: begin
        if (count_hit(dl_bit_sample, 1'b1)) begin
          sq_shift = {sq_shift[BYTE_W-2:0], lvl};
          sq_count = '0;
          if (sq_bit_idx == BIT_IDX_W'(BYTE_W - 1)) begin
            sq_bit_idx = '0;
            sq_phase   = PH_IDLE;
            fin        = 1'b1;
            bytes_done++;
          end else begin
            sq_bit_idx = sq_bit_idx + BIT_IDX_W'(1);
            sq_phase   = PH_WAIT_LOW;
          end
        end
      end
      default: sq_phase = PH_IDLE;
    endcase
    w.drive_low  = (sq_phase == PH_START_LOW);
    w.busy_res   = (sq_phase != PH_IDLE);
    w.done_res   = fin;
    w.ack_ok     = sq_ack;
    w.byte_value = sq_shift;
    expected_words.push_back(w);
  endtask

  // line level that moves the predicted sequence along, flipped at noise %
  function automatic logic pick_level(input int noise);
    logic lvl;
    case (sq_phase)
      PH_ACK1:      lvl = ($urandom_range(99) < noise);
      PH_ACK2:      lvl = !($urandom_range(99) < noise);
      PH_WAIT_LOW:  lvl = ($urandom_range(99) < 4 * noise);
      PH_WAIT_HIGH: begin
        bit_lvl = 1'($urandom_range(1));
        lvl     = !($urandom_range(99) < 4 * noise);
      end
      PH_SAMPLE:    lvl = bit_lvl ^ ($urandom_range(99) < noise);
      default:      lvl = 1'($urandom_range(1));
    endcase
    return lvl;
  endfunction

  // ---------------- stimulus side ----------------
  task automatic send_tick(input action_t act, input logic lvl);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_line_level <= lvl;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    step_sequencer(act, lvl);
    ticks_sent++;
  endtask

  task automatic pause_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // finish any running operation, then wait for all result words
  task automatic settle();
    while (sq_phase != PH_IDLE) send_tick(ACT_TICK, pick_level(0));
    pause_for_drain();
  endtask

  task automatic load_delays(input cfg_val_t sl, input cfg_val_t fa, input cfg_val_t sa,
                             input cfg_val_t at, input cfg_val_t bs);
    cfg_val_t vals[5];
    cfg_idx_t idxs[5];
    vals = '{sl, fa, sa, at, bs};
    idxs = '{REG_START_LOW, REG_FIRST_ACK, REG_SECOND_ACK, REG_ACK_TAIL, REG_BIT_SAMPLE};
    settle();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we        <= 1'b0;
    dl_start_low  = sl;
    dl_first_ack  = fa;
    dl_second_ack = sa;
    dl_ack_tail   = at;
    dl_bit_sample = bs;
  endtask

  function automatic cfg_val_t pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 70) return cfg_val_t'($urandom_range(1, 5));
    return cfg_val_t'($urandom_range(6, 24));
  endfunction

  // ---------------- result checking ----------------
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic check_field(input string fname, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      err_cnt++;
    end
  endtask

  // outputs are stable here and the word is taken at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word with no tick word pending");
        err_cnt++;
      end else begin
        head_word = expected_words.pop_front();
        check_field("drive_low", BYTE_W'(head_word.drive_low), BYTE_W'(out_drive_low));
        check_field("busy_res", BYTE_W'(head_word.busy_res), BYTE_W'(out_busy_res));
        check_field("done_res", BYTE_W'(head_word.done_res), BYTE_W'(out_done_res));
        check_field("ack_ok", BYTE_W'(head_word.ack_ok), BYTE_W'(out_ack_ok));
        check_field("byte_value", head_word.byte_value, out_byte_value);
        words_checked++;
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_default_timing();
    // receive with every delay at its reset value
    send_tick(ACT_RECV, 1'b1);
    settle();
    // short start pulse, acknowledge delays still at reset values
    load_delays(cfg_val_t'(20), RST_FIRST_ACK, RST_SECOND_ACK, RST_ACK_TAIL, RST_BIT_SAMPLE);
    send_tick(ACT_START, 1'b1);
    settle();
  endtask

  task automatic test_start_ack();
    // zero delays act as one tick, zero tail ends on the second sample
    load_delays('0, cfg_val_t'(1), '0, '0, '0);
    send_tick(ACT_START, 1'b1);
    send_tick(ACT_RECV, 1'b0);     // ignored while busy; first sample low
    send_tick(ACT_TICK, 1'b1);     // second sample high: acknowledged
    send_tick(ACT_START, 1'b0);
    send_tick(ACT_START, 1'b1);    // ignored; first sample high: no ack
    send_tick(ACT_SPARE, 1'b1);
    send_tick(ACT_SPARE, 1'b0);    // unused code from idle does nothing
  endtask

  task automatic test_receive_byte();
    logic [BYTE_W-1:0] pattern;
    pattern = 8'hA5;
    send_tick(ACT_RECV, 1'b0);     // line not looked at on the command tick
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      send_tick(ACT_TICK, 1'b0);
      send_tick(ACT_TICK, 1'b1);
      send_tick(ACT_TICK, pattern[i]);
    end
  endtask

  task automatic test_long_delays();
    send_gap_pct = 0;
    stall_pct    = 0;
    load_delays(cfg_val_t'(256), cfg_val_t'(1), cfg_val_t'(1), '0, cfg_val_t'(1));
    send_tick(ACT_START, 1'b1);
    settle();
    load_delays(cfg_val_t'(1), cfg_val_t'(2), cfg_val_t'(1), cfg_val_t'(128), cfg_val_t'(2));
    send_tick(ACT_START, 1'b0);
    settle();
  endtask

  task automatic test_pause_drain();
    send_tick(ACT_RECV, 1'b1);
    for (int i = 0; i < 7; i++) send_tick(ACT_TICK, pick_level(0));
    // hold off mid-byte until every result word is back
    pause_for_drain();
    settle();
  endtask

  task automatic test_random_traffic();
    int      gap_tbl[4];
    int      stall_tbl[4];
    int      r;
    action_t act;
    logic    lvl;
    gap_tbl   = '{0, 70, 0, 31};
    stall_tbl = '{0, 0, 70, 31};
    for (int p = 0; p < 4; p++) begin
      send_gap_pct = gap_tbl[p];
      stall_pct    = stall_tbl[p];
      load_delays(pick_delay(), pick_delay(), pick_delay(), pick_delay(), pick_delay());
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(99) == 0) pause_for_drain();
        if (sq_phase == PH_IDLE) begin
          r = $urandom_range(99);
          if (r < 42) act = ACT_START;
          else if (r < 84) act = ACT_RECV;
          else act = action_t'($urandom_range(3));
          lvl = 1'($urandom_range(1));
        end else begin
          act = ($urandom_range(99) < 6) ? action_t'($urandom_range(3)) : ACT_TICK;
          lvl = pick_level(8);
        end
        send_tick(act, lvl);
      end
      settle();
    end
    send_gap_pct = 0;
    stall_pct    = 0;
  endtask

  initial begin
    int wait_cycles;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_timing();
    test_start_ack();
    test_receive_byte();
    test_pause_drain();
    test_long_delays();
    test_random_traffic();

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (expected_words.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      err_cnt++;
    end
    $display("covered %0d tick words, %0d result words checked", ticks_sent, words_checked);
    $display("start sequences: %0d acknowledged, %0d not; bytes received: %0d",
             acks_ok, acks_bad, bytes_done);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
